// ===== sv/qphm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphm_pkg
// Shared widths, opcodes and status codes of the quadratic-probe hash map.
// ----------------------------------------------------------------------------
package qphm_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1021;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 10;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_KEY_ZERO = 2'd2
  } status_e;

endpackage

// ===== sv/qphm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphm request / response interfaces
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface qphm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [qphm_pkg::KEY_W-1:0]  key;
  logic [qphm_pkg::VAL_W-1:0]  value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface qphm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [qphm_pkg::VAL_W-1:0]  value_out;
  qphm_pkg::status_e           status;
  logic [qphm_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output found, output value_out, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input found, input value_out, input status,
                  input occupancy, output ready);
endinterface

// ===== sv/quadratic_probe_hash_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_map_top
// Open-addressing map of 32-bit keys to 32-bit values, quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one word per request: operation (0 get, 1 set), key, value.
//   rsp_o returns one word per request: found, value_out, status, occupancy.
//   Probe i visits slot (key + i*i) mod TABLE_SIZE; the walk stops on a match,
//   on an empty slot or after TABLE_SIZE probes.
// Sequence:
//   After accept, the multiply states S_MUL_HI and S_MUL_LO form a reciprocal
//   estimate of key mod TABLE_SIZE, the reduce state S_REDUCE corrects it and
//   issues the first read, then S_PROBE makes one probe per cycle, bounded by
//   the registered read of the key/value memories; the final probe holds while the response register is full.
//   A new request is taken in the cycle after the previous one is finished,
//   so one request is worked on at a time. Key zero skips the multiply and
//   probe states; S_ZERO loads its response once the response register is free.
// Reset:
//   After rst_ni releases, a clearing pass in S_CLEAR writes every
//   key slot to zero (empty); req_i.ready stays low until it is done.
// Stall:
//   The response sits in an output register. While it waits, the next request
//   is accepted and worked on; only its final probe holds until the register
//   frees, re-reading the same slot, with no write done.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_map_top #(
  parameter int unsigned TABLE_SIZE = qphm_pkg::TABLE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  qphm_req_if.sink          req_i,
  qphm_rsp_if.source        rsp_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned KEY_W  = qphm_pkg::KEY_W;
  localparam int unsigned VAL_W  = qphm_pkg::VAL_W;
  localparam int unsigned OCC_W  = qphm_pkg::OCC_W;

  // floor(2^32 / N): estimate of key / N is low by at most one
  localparam logic [31:0]       RECIP     = 32'((64'd1 << 32) / TABLE_SIZE);
  localparam logic [31:0]       SIZE_32   = 32'(TABLE_SIZE);
  localparam logic [ADDR_W:0]   SIZE_EXT  = (ADDR_W + 1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]  SIZE_CNT  = CNT_W'(TABLE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ZERO,
    S_MUL_HI,
    S_MUL_LO,
    S_REDUCE,
    S_PROBE
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e              state_q;
  logic [ADDR_W-1:0]   clr_addr_q;
  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [63:0]         prod_hi_q;   // key * RECIP
  logic [31:0]         prod_lo_q;   // quotient estimate * N, low word
  logic [ADDR_W-1:0]   slot_q;      // slot whose data is on the read port
  logic [ADDR_W-1:0]   delta_q;     // (2i + 1) mod N, step to the next slot
  logic [CNT_W-1:0]    probe_cnt_q; // probes issued for this request
  logic [CNT_W-1:0]    fill_cnt_q;
  logic                out_valid_q;
  logic                out_found_q;
  logic [VAL_W-1:0]    out_value_q;
  qphm_pkg::status_e   out_status_q;
  logic [OCC_W-1:0]    out_occ_q;

  // Memories, registered read
  logic [KEY_W-1:0]    key_mem [TABLE_SIZE];
  logic [VAL_W-1:0]    val_mem [TABLE_SIZE];
  logic [KEY_W-1:0]    key_rd_q;
  logic [VAL_W-1:0]    val_rd_q;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic                out_free;
  logic                out_load;
  logic [31:0]         rem_raw;
  logic [31:0]         rem_red;
  logic [ADDR_W-1:0]   base_slot;
  logic [ADDR_W:0]     step_sum;
  logic [ADDR_W-1:0]   next_slot;
  logic [ADDR_W:0]     delta_sum;
  logic [ADDR_W-1:0]   next_delta;
  logic                hit;
  logic                empty;
  logic                exhausted;
  logic                probe_final;
  logic                finish;
  logic                ins_we;
  logic                key_we;
  logic [ADDR_W-1:0]   key_waddr;
  logic [KEY_W-1:0]    key_wdata;
  logic                val_we;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    fill_cnt_d;
  logic                res_found;
  logic [VAL_W-1:0]    res_value;
  qphm_pkg::status_e   res_status;

  assign out_free = !out_valid_q || rsp_o.ready;

  // key mod N: remainder of the estimate is below 2N, one correction
  assign rem_raw   = key_q - prod_lo_q;
  assign rem_red   = (rem_raw >= SIZE_32) ? (rem_raw - SIZE_32) : rem_raw;
  assign base_slot = rem_red[ADDR_W-1:0];

  // slot(i+1) = slot(i) + (2i + 1), all mod N
  assign step_sum   = {1'b0, slot_q} + {1'b0, delta_q};
  assign next_slot  = (step_sum >= SIZE_EXT) ? ADDR_W'(step_sum - SIZE_EXT)
                                             : step_sum[ADDR_W-1:0];
  assign delta_sum  = {1'b0, delta_q} + (ADDR_W + 1)'(2);
  assign next_delta = (delta_sum >= SIZE_EXT) ? ADDR_W'(delta_sum - SIZE_EXT)
                                              : delta_sum[ADDR_W-1:0];

  assign empty       = (key_rd_q == '0);
  assign hit         = (key_rd_q == key_q);
  assign exhausted   = (probe_cnt_q == SIZE_CNT);
  assign probe_final = empty || hit || exhausted;
  assign finish      = (state_q == S_PROBE) && probe_final && out_free;

  // response register loads on a finished walk or a key-zero answer
  assign out_load = finish || ((state_q == S_ZERO) && out_free);

  // insert into an empty slot, or overwrite the value of a present key
  assign ins_we = finish && (op_q == qphm_pkg::OP_SET) && empty;
  assign val_we = finish && (op_q == qphm_pkg::OP_SET) && (empty || hit);

  assign key_we    = (state_q == S_CLEAR) || ins_we;
  assign key_waddr = (state_q == S_CLEAR) ? clr_addr_q : slot_q;
  assign key_wdata = (state_q == S_CLEAR) ? '0 : key_q;

  always_comb begin
    case (state_q)
      S_REDUCE: rd_addr = base_slot;
      S_PROBE:  rd_addr = probe_final ? slot_q : next_slot;
      default:  rd_addr = slot_q;
    endcase
  end

  assign fill_cnt_d = ins_we ? (fill_cnt_q + CNT_W'(1)) : fill_cnt_q;

  assign res_found  = hit && !empty;
  assign res_value  = ((op_q == qphm_pkg::OP_GET) && res_found) ? val_rd_q : '0;
  assign res_status = ((op_q == qphm_pkg::OP_SET) && !empty && !hit)
                      ? qphm_pkg::STATUS_FULL : qphm_pkg::STATUS_OK;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[slot_q] <= val_q;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control FSM and response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      op_q         <= qphm_pkg::OP_GET;
      key_q        <= '0;
      val_q        <= '0;
      prod_hi_q    <= '0;
      prod_lo_q    <= '0;
      slot_q       <= '0;
      delta_q      <= '0;
      probe_cnt_q  <= '0;
      fill_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= qphm_pkg::STATUS_OK;
      out_occ_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      fill_cnt_q <= fill_cnt_d;

      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + ADDR_W'(1);
          if (clr_addr_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            op_q  <= req_i.operation;
            key_q <= req_i.key;
            val_q <= req_i.value;
            state_q <= (req_i.key == '0) ? S_ZERO : S_MUL_HI;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            out_found_q  <= 1'b0;
            out_value_q  <= '0;
            out_status_q <= qphm_pkg::STATUS_KEY_ZERO;
            out_occ_q    <= OCC_W'(fill_cnt_q);
            state_q      <= S_IDLE;
          end
        end
        S_MUL_HI: begin
          prod_hi_q <= 64'(key_q) * 64'(RECIP);
          state_q   <= S_MUL_LO;
        end
        S_MUL_LO: begin
          prod_lo_q <= 32'(prod_hi_q[63:32] * SIZE_32);
          state_q   <= S_REDUCE;
        end
        S_REDUCE: begin
          slot_q      <= base_slot;
          delta_q     <= ADDR_W'(1);
          probe_cnt_q <= CNT_W'(1);
          state_q     <= S_PROBE;
        end
        S_PROBE: begin
          if (!probe_final) begin
            slot_q      <= next_slot;
            delta_q     <= next_delta;
            probe_cnt_q <= probe_cnt_q + CNT_W'(1);
          end else if (out_free) begin
            out_found_q  <= res_found;
            out_value_q  <= res_value;
            out_status_q <= res_status;
            out_occ_q    <= OCC_W'(fill_cnt_d);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.found     = out_found_q;
  assign rsp_o.value_out = out_value_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.occupancy = out_occ_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q <= SIZE_CNT)
    else $error("fill count above table size");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe_cnt_q <= SIZE_CNT)
    else $error("probe count above table size");

  a_no_zero_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_we |-> (key_q != '0))
    else $error("empty mark written as a key");

  a_fill_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_cnt_q != $past(fill_cnt_q)) |-> $past(ins_we))
    else $error("fill count changed without an insert");

  a_no_write_in_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!ins_we && !val_we && !out_valid_q))
    else $error("table access during clearing pass");

endmodule
